>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> hdl/i2cms_pkg.sv
// Types and constants for the I2C master bit sequencer.
package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WAIT  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6,
    CMD_IDLE  = 3'd7
  } cmd_e;

  localparam int unsigned STEP_W      = 3;
  localparam int unsigned BIT_IDX_W   = 4;
  localparam int unsigned PHASE_W     = 16;
  localparam int unsigned TIMEOUT_W   = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd1;
  localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

  // Bus drive levels.
  typedef struct packed {
    logic scl;
    logic sda;
    logic dir;
  } bus_t;

  // One result item.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       dir;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } res_t;

endpackage

>>> hdl/i2cms_core.sv
// Sequencer state and single-tick next-state logic of the I2C master.
module i2cms_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  logic                                cmd_valid_i,
  input  logic [2:0]                          req_type_i,
  input  logic [7:0]                          tx_byte_i,
  input  logic                                ack_after_read_i,
  input  logic                                sda_in_i,
  input  logic [i2cms_pkg::PHASE_W-1:0]       phase_ticks_i,
  input  logic [i2cms_pkg::TIMEOUT_W-1:0]     ack_timeout_i,
  output i2cms_pkg::res_t                     res_o
);

  i2cms_pkg::cmd_e                          cmd_q, cmd_d;
  logic [i2cms_pkg::STEP_W-1:0]             step_q, step_d;
  logic [i2cms_pkg::BIT_IDX_W-1:0]          bit_idx_q, bit_idx_d;
  logic [7:0]                               shift_q, shift_d;
  logic [i2cms_pkg::PHASE_W-1:0]            cnt_q, cnt_d;
  logic [i2cms_pkg::TIMEOUT_W-1:0]          poll_q, poll_d;
  i2cms_pkg::bus_t                          bus_q, bus_d;
  logic                                     fail_q, fail_d;
  logic                                     ackc_q, ackc_d;
  logic [7:0]                               rx_q, rx_d;

  logic [i2cms_pkg::PHASE_W-1:0]            cnt_inc;
  logic [i2cms_pkg::PHASE_W-1:0]            phase_len;
  logic                                     phase_end;
  logic [i2cms_pkg::BIT_IDX_W-1:0]          bit_inc;
  logic                                     start;
  logic                                     done;
  logic                                     ev_enter;
  logic                                     ev_scl_low;
  logic                                     ev_shift_wr;
  logic                                     ev_shift_rd;
  logic                                     ev_poll_inc;
  logic                                     ev_ack_ok;
  logic                                     ev_ack_fail;
  logic                                     ev_rx;
  i2cms_pkg::bus_t                          bus_base;

  // Levels driven on entry to a step of a command.
  function automatic i2cms_pkg::bus_t enter_lvls(
    input i2cms_pkg::cmd_e              c,
    input logic [i2cms_pkg::STEP_W-1:0] s,
    input logic                         msb,
    input logic                         ackc,
    input i2cms_pkg::bus_t              b
  );
    i2cms_pkg::bus_t r;
    r = b;
    case (c)
      i2cms_pkg::CMD_START: begin
        if (s == '0) begin
          r.dir = 1'b1; r.sda = 1'b1; r.scl = 1'b1;
        end else begin
          r.sda = 1'b0;
        end
      end
      i2cms_pkg::CMD_STOP: begin
        if (s == '0) begin
          r.dir = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
        end else begin
          r.scl = 1'b1; r.sda = 1'b1;
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        if (s == 3'd0) begin
          r.dir = 1'b1; r.scl = 1'b0; r.sda = msb;
        end else if (s == 3'd1) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      i2cms_pkg::CMD_READ: begin
        if (s == 3'd0) begin
          r.scl = 1'b0; r.dir = 1'b0;
        end else if (s == 3'd2) begin
          r.scl = 1'b0; r.dir = 1'b1; r.sda = ~ackc;
        end else begin
          r.scl = 1'b1;
        end
      end
      i2cms_pkg::CMD_WAIT: begin
        if (s == 3'd0) begin
          r.dir = 1'b0; r.sda = 1'b1;
        end else if (s == 3'd1) begin
          r.scl = 1'b1;
        end else if (s == 3'd2) begin
          r.dir = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
        end else begin
          r.scl = 1'b1; r.sda = 1'b1;
        end
      end
      i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
        if (s == '0) begin
          r.scl = 1'b0; r.dir = 1'b1; r.sda = (c == i2cms_pkg::CMD_NACK);
        end else begin
          r.scl = 1'b1;
        end
      end
      default: begin
        r = b;
      end
    endcase
    return r;
  endfunction

  assign cnt_inc   = cnt_q + 16'd1;
  assign phase_len = (phase_ticks_i == '0) ? 16'd1 : phase_ticks_i;
  assign phase_end = (cnt_inc >= phase_len);
  assign bit_inc   = bit_idx_q + 4'd1;

  // Next command and step, plus the events of this tick.
  always_comb begin
    cmd_d       = cmd_q;
    step_d      = step_q;
    start       = 1'b0;
    done        = 1'b0;
    ev_enter    = 1'b0;
    ev_scl_low  = 1'b0;
    ev_shift_wr = 1'b0;
    ev_shift_rd = 1'b0;
    ev_poll_inc = 1'b0;
    ev_ack_ok   = 1'b0;
    ev_ack_fail = 1'b0;
    ev_rx       = 1'b0;
    if (cmd_q == i2cms_pkg::CMD_IDLE) begin
      if (cmd_valid_i && (i2cms_pkg::cmd_e'(req_type_i) != i2cms_pkg::CMD_IDLE)) begin
        start    = 1'b1;
        cmd_d    = i2cms_pkg::cmd_e'(req_type_i);
        step_d   = '0;
        ev_enter = 1'b1;
      end
    end else if (phase_end) begin
      case (cmd_q)
        i2cms_pkg::CMD_START, i2cms_pkg::CMD_STOP,
        i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
          if (step_q == '0) begin
            step_d   = 3'd1;
            ev_enter = 1'b1;
          end else begin
            done       = 1'b1;
            ev_scl_low = (cmd_q inside {i2cms_pkg::CMD_START, i2cms_pkg::CMD_ACK,
                                        i2cms_pkg::CMD_NACK});
          end
        end
        i2cms_pkg::CMD_WRITE: begin
          if (step_q < 3'd2) begin
            step_d   = step_q + 3'd1;
            ev_enter = 1'b1;
          end else begin
            ev_shift_wr = 1'b1;
            if (bit_inc >= i2cms_pkg::BITS_PER_BYTE) begin
              done = 1'b1;
            end else begin
              step_d   = '0;
              ev_enter = 1'b1;
            end
          end
        end
        i2cms_pkg::CMD_READ: begin
          case (step_q)
            3'd0, 3'd2: begin
              step_d   = step_q + 3'd1;
              ev_enter = 1'b1;
            end
            3'd1: begin
              ev_shift_rd = 1'b1;
              step_d      = (bit_inc >= i2cms_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd0;
              ev_enter    = 1'b1;
            end
            3'd3: begin
              ev_rx      = 1'b1;
              ev_scl_low = 1'b1;
              done       = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
        i2cms_pkg::CMD_WAIT: begin
          case (step_q)
            3'd0, 3'd2: begin
              step_d   = step_q + 3'd1;
              ev_enter = 1'b1;
            end
            3'd1: begin
              if (!sda_in_i) begin
                ev_scl_low = 1'b1;
                ev_ack_ok  = 1'b1;
                done       = 1'b1;
              end else if (poll_q >= ack_timeout_i) begin
                // out of polls: go on to the stop
                step_d   = 3'd2;
                ev_enter = 1'b1;
              end else begin
                ev_poll_inc = 1'b1;
              end
            end
            3'd3: begin
              ev_ack_fail = 1'b1;
              done        = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    if (done) begin
      cmd_d  = i2cms_pkg::CMD_IDLE;
      step_d = '0;
    end
  end

  // Datapath and bus levels.
  always_comb begin
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    fail_d    = fail_q;
    ackc_d    = ackc_q;
    rx_d      = rx_q;
    if (cmd_q == i2cms_pkg::CMD_IDLE) begin
      cnt_d = start ? '0 : cnt_q;
    end else begin
      cnt_d = phase_end ? '0 : cnt_inc;
    end
    if (start) begin
      bit_idx_d = '0;
      poll_d    = '0;
      if (cmd_d == i2cms_pkg::CMD_WRITE) begin
        shift_d = tx_byte_i;
      end
      if (cmd_d == i2cms_pkg::CMD_READ) begin
        shift_d = '0;
        ackc_d  = ack_after_read_i;
      end
      if (cmd_d == i2cms_pkg::CMD_WAIT) begin
        fail_d = 1'b0;
      end
    end
    if (ev_shift_wr) begin
      shift_d   = {shift_q[6:0], 1'b0};
      bit_idx_d = bit_inc;
    end
    if (ev_shift_rd) begin
      shift_d   = {shift_q[6:0], sda_in_i};
      bit_idx_d = bit_inc;
    end
    if (ev_poll_inc) begin
      poll_d = poll_q + 8'd1;
    end
    if (ev_ack_ok) begin
      fail_d = 1'b0;
    end
    if (ev_ack_fail) begin
      fail_d = 1'b1;
    end
    if (ev_rx) begin
      rx_d = shift_q;
    end
    bus_base = bus_q;
    if (ev_scl_low) begin
      bus_base.scl = 1'b0;
    end
    bus_d = ev_enter ? enter_lvls(cmd_d, step_d, shift_d[7], ackc_d, bus_base) : bus_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= i2cms_pkg::CMD_IDLE;
      step_q    <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      cnt_q     <= '0;
      poll_q    <= '0;
      bus_q     <= '{scl: 1'b1, sda: 1'b1, dir: 1'b1};
      fail_q    <= 1'b0;
      ackc_q    <= 1'b0;
      rx_q      <= '0;
    end else if (tick_i) begin
      cmd_q     <= cmd_d;
      step_q    <= step_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      cnt_q     <= cnt_d;
      poll_q    <= poll_d;
      bus_q     <= bus_d;
      fail_q    <= fail_d;
      ackc_q    <= ackc_d;
      rx_q      <= rx_d;
    end
  end

  assign res_o.scl  = bus_d.scl;
  assign res_o.sda  = bus_d.sda;
  assign res_o.dir  = bus_d.dir;
  assign res_o.busy = (cmd_d != i2cms_pkg::CMD_IDLE);
  assign res_o.done = done;
  assign res_o.rx   = rx_d;
  assign res_o.fail = fail_d;

endmodule

>>> hdl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer top level: configuration registers, sequencer and output buffer.
// Each input item is one bus tick carrying the sampled SDA level and, while idle, an optional
// command (start, stop, write byte, read byte with ACK/NACK, wait for ACK, send ACK/NACK).
// Every accepted item yields exactly one result item with the SCL/SDA drive levels after that
// tick, busy/done flags, the last read byte and the ACK failure flag. One item is taken per
// clock cycle unless in_stall_o is high; its result is registered in the output buffer. The
// rate is set by the single-pass next-state logic of the sequencer, which updates its state on
// every accepted tick. A two-entry output buffer keeps the input side running for one more
// item while a result waits on out_stall_i. phase_ticks sets the ticks per half phase of SCL
// (0 acts as 1); ack_timeout sets how many high polls a wait for ACK allows before it sends a
// stop and fails. Write configuration only while no command is in progress.
module i2c_master_bit_sequencer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_valid_i,
  input  logic [2:0]                            req_type_i,
  input  logic [7:0]                            tx_byte_i,
  input  logic                                  ack_after_read_i,
  input  logic                                  sda_in_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  scl_level_o,
  output logic                                  sda_level_o,
  output logic                                  sda_driving_o,
  output logic                                  busy_res_o,
  output logic                                  done_res_o,
  output logic [7:0]                            rx_byte_o,
  output logic                                  ack_failed_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [i2cms_pkg::PHASE_W-1:0]         cfg_data_i
);

  logic [i2cms_pkg::PHASE_W-1:0]   phase_ticks_q;
  logic [i2cms_pkg::TIMEOUT_W-1:0] ack_timeout_q;

  logic            accept;
  logic            out_take;
  i2cms_pkg::res_t res;
  i2cms_pkg::res_t out_q, out_d;
  i2cms_pkg::res_t skid_q, skid_d;
  logic            out_vld_q, out_vld_d;
  logic            skid_vld_q, skid_vld_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cms_pkg::PHASE_TICKS_RST;
      ack_timeout_q <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        i2cms_pkg::CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        i2cms_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[i2cms_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;

  i2cms_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (accept),
    .cmd_valid_i     (cmd_valid_i),
    .req_type_i      (req_type_i),
    .tx_byte_i       (tx_byte_i),
    .ack_after_read_i(ack_after_read_i),
    .sda_in_i        (sda_in_i),
    .phase_ticks_i   (phase_ticks_q),
    .ack_timeout_i   (ack_timeout_q),
    .res_o           (res)
  );

  // Output register with one skid entry behind it.
  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_take) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = accept;
      end
    end else if (accept) begin
      // hold the new item until the output frees up
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_vld_q;
  assign scl_level_o   = out_q.scl;
  assign sda_level_o   = out_q.sda;
  assign sda_driving_o = out_q.dir;
  assign busy_res_o    = out_q.busy;
  assign done_res_o    = out_q.done;
  assign rx_byte_o     = out_q.rx;
  assign ack_failed_o  = out_q.fail;

endmodule

>>> hdl/i2cms_checker.sv
// Port-level checks for the I2C master bit sequencer and their binding.
`include "assert_macros.svh"

module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       scl_level_o,
  input logic       sda_level_o,
  input logic       sda_driving_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] rx_byte_o,
  input logic       ack_failed_o
);

  logic        out_hold;
  logic [13:0] res_bits;

  assign out_hold = out_valid_o && out_stall_i;
  assign res_bits = {scl_level_o, sda_level_o, sda_driving_o, busy_res_o, done_res_o,
                     rx_byte_o, ack_failed_o};

  // a finished command leaves the sequencer idle
  `ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o)

  // an accepted tick leaves a result valid on the next cycle
  `ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

  // the input side only stalls while a result is waiting
  `ASSERT_IMPL(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)

  // hold a stalled result item unchanged
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(res_bits))

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (.*);
